### design/blm_pkg.sv
// Battery level monitor package: transaction structs, register reset values,
// shared widths and constants. No dependencies.

package blm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLES_DEF = 5;

  // scaling datapath widths
  localparam int NUM_W  = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 2;
  localparam int PROD_W = NUM_W - 1 + 7;

  localparam logic [6:0]             PCT_MAX        = 7'd100;
  localparam logic [SAMPLE_BITS-1:0] FULL_LEVEL_RST = SAMPLE_BITS'(3900);
  localparam logic [1:0]             STATUS_RST     = 2'd3;
  localparam logic [2:0]             HOLD_CNT_RST   = 3'd5;

  localparam logic [7:0]  PERIOD_RST = 8'd5;
  localparam logic [11:0] SPAN_RST   = 12'd900;
  localparam logic [6:0]  THR_FULL_RST = 7'd70;
  localparam logic [6:0]  THR_MID_RST  = 7'd45;
  localparam logic [6:0]  THR_LOW_RST  = 7'd20;
  localparam logic [2:0]  HOLD_RST     = 3'd5;

  localparam logic [2:0] REG_PERIOD   = 3'd0;
  localparam logic [2:0] REG_SPAN     = 3'd1;
  localparam logic [2:0] REG_THR_FULL = 3'd2;
  localparam logic [2:0] REG_THR_MID  = 3'd3;
  localparam logic [2:0] REG_THR_LOW  = 3'd4;
  localparam logic [2:0] REG_HOLD     = 3'd5;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_CAL  = 1'b1;

  typedef struct packed {
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic [6:0] percent;
    logic [1:0] level_status;
    logic       sampled;
  } out_t;

  typedef struct packed {
    logic [7:0]  sample_period;
    logic [11:0] span;
    logic [6:0]  thr_full;
    logic [6:0]  thr_mid;
    logic [6:0]  thr_low;
    logic [2:0]  hold_count;
  } cfg_t;

endpackage

### design/blm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module blm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 5,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/blm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.

module blm_div #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_r, quo_r, dvs_r;
  logic [W-1:0]     rem_nxt, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [W:0]       rem_sh, diff;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[W-1]};
    diff    = rem_sh - {1'b0, dvs_r};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### design/blm_regs.sv
// APB configuration register file for the battery level monitor.
// Depends on blm_pkg.

module blm_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output blm_pkg::cfg_t     cfg
);

  blm_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period <= blm_pkg::PERIOD_RST;
      cfg_r.span          <= blm_pkg::SPAN_RST;
      cfg_r.thr_full      <= blm_pkg::THR_FULL_RST;
      cfg_r.thr_mid       <= blm_pkg::THR_MID_RST;
      cfg_r.thr_low       <= blm_pkg::THR_LOW_RST;
      cfg_r.hold_count    <= blm_pkg::HOLD_RST;
    end else if (wr) begin
      unique case (idx)
        blm_pkg::REG_PERIOD:   cfg_r.sample_period <= pwdata[7:0];
        blm_pkg::REG_SPAN:     cfg_r.span          <= pwdata[11:0];
        blm_pkg::REG_THR_FULL: cfg_r.thr_full      <= pwdata[6:0];
        blm_pkg::REG_THR_MID:  cfg_r.thr_mid       <= pwdata[6:0];
        blm_pkg::REG_THR_LOW:  cfg_r.thr_low       <= pwdata[6:0];
        blm_pkg::REG_HOLD:     cfg_r.hold_count    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      blm_pkg::REG_PERIOD:   prdata = 32'(cfg_r.sample_period);
      blm_pkg::REG_SPAN:     prdata = 32'(cfg_r.span);
      blm_pkg::REG_THR_FULL: prdata = 32'(cfg_r.thr_full);
      blm_pkg::REG_THR_MID:  prdata = 32'(cfg_r.thr_mid);
      blm_pkg::REG_THR_LOW:  prdata = 32'(cfg_r.thr_low);
      blm_pkg::REG_HOLD:     prdata = 32'(cfg_r.hold_count);
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### design/battery_level_monitor.sv
// Battery level monitor: moving average gauge with hysteresis status.
// Calibrate and count-down ticks: the result is registered from the accepted
// transaction. Sampling ticks walk the RAM to sum the filled entries, divide by
// the fill count on the bit-serial divider, then scale to a percentage with a
// second divider pass (skipped when no scaling division is needed) before the
// status update. One item at a time. Synchronous active-low reset; the window
// RAM is not cleared, only entries already written are averaged.
// Depends on blm_pkg, blm_regs, blm_ram, blm_div.

module battery_level_monitor #(
  parameter int SAMPLES = blm_pkg::SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  blm_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output blm_pkg::out_t         out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [4:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SB     = blm_pkg::SAMPLE_BITS;
  localparam int CNT_W  = $clog2(SAMPLES + 1);
  localparam int IDX_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int SUM_W  = SB + $clog2(SAMPLES);
  localparam int NUM_W  = blm_pkg::NUM_W;
  localparam int PROD_W = blm_pkg::PROD_W;
  localparam int DIV_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_AVGGO = 3'd2;
  localparam logic [2:0] S_AVGW  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_PCTGO = 3'd5;
  localparam logic [2:0] S_PCTW  = 3'd6;
  localparam logic [2:0] S_STAT  = 3'd7;

  blm_pkg::cfg_t cfg;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  wi_r, wi_nxt;
  logic [7:0]        tick_r, tick_nxt;
  logic [SB-1:0]     full_r, full_nxt;
  logic [6:0]        pct_r, pct_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [2:0]        hold_r, hold_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              acc_vld_r, acc_vld_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SB-1:0]     avg_r, avg_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  blm_pkg::out_t     out_r, out_nxt;

  logic              in_fire;
  logic              ram_we, ram_re;
  logic [SB-1:0]     ram_rdata;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dividend, div_divisor, div_quo;
  logic [NUM_W-1:0]  num;
  logic              num_pos;
  logic [1:0]        step;

  blm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  blm_ram #(
    .WIDTH (SB),
    .DEPTH (SAMPLES),
    .AW    (IDX_W)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wi_r),
    .wdata (in_data.sample),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  blm_div #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ram_we = in_fire && (in_data.cmd == blm_pkg::CMD_TICK) && (tick_r == 8'd0);
  assign ram_re = (state_r == S_SUM) && (rd_idx_r < fill_r);

  assign div_start    = (state_r == S_AVGGO) || (state_r == S_PCTGO);
  assign div_dividend = (state_r == S_AVGGO) ? DIV_W'(sum_r) : DIV_W'(prod_r);
  assign div_divisor  = (state_r == S_AVGGO) ? DIV_W'(fill_r) : DIV_W'(cfg.span);

  assign num     = NUM_W'(avg_r) + NUM_W'(cfg.span) - NUM_W'(full_r);
  assign num_pos = !num[NUM_W-1] && (num != '0);

  always_comb begin
    if (pct_r >= cfg.thr_full) begin
      step = 2'd3;
    end else if (pct_r >= cfg.thr_mid) begin
      step = 2'd2;
    end else if (pct_r >= cfg.thr_low) begin
      step = 2'd1;
    end else begin
      step = 2'd0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    wi_nxt        = wi_r;
    tick_nxt      = tick_r;
    full_nxt      = full_r;
    pct_nxt       = pct_r;
    status_nxt    = status_r;
    hold_nxt      = hold_r;
    rd_idx_nxt    = rd_idx_r;
    acc_vld_nxt   = acc_vld_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == blm_pkg::CMD_CAL) begin
            full_nxt      = in_data.sample;
            out_valid_nxt = 1'b1;
            out_nxt       = '{percent: pct_r, level_status: status_r, sampled: 1'b0};
          end else if (tick_r != 8'd0) begin
            tick_nxt      = tick_r - 8'd1;
            out_valid_nxt = 1'b1;
            out_nxt       = '{percent: pct_r, level_status: status_r, sampled: 1'b0};
          end else begin
            if (fill_r < CNT_W'(SAMPLES)) begin
              fill_nxt = fill_r + 1'b1;
            end
            wi_nxt      = (wi_r == IDX_W'(SAMPLES - 1)) ? '0 : wi_r + 1'b1;
            tick_nxt    = cfg.sample_period;
            rd_idx_nxt  = '0;
            acc_vld_nxt = 1'b0;
            sum_nxt     = '0;
            state_nxt   = S_SUM;
          end
        end
      end
      S_SUM: begin
        acc_vld_nxt = ram_re;
        if (ram_re) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (acc_vld_r) begin
          sum_nxt = sum_r + SUM_W'(ram_rdata);
        end
        if (!ram_re && !acc_vld_r) begin
          state_nxt = S_AVGGO;
        end
      end
      S_AVGGO: state_nxt = S_AVGW;
      S_AVGW: begin
        if (div_done) begin
          avg_nxt   = div_quo[SB-1:0];
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (cfg.span == 12'd0) begin
          pct_nxt   = (avg_r >= full_r) ? blm_pkg::PCT_MAX : 7'd0;
          state_nxt = S_STAT;
        end else if (!num_pos) begin
          pct_nxt   = 7'd0;
          state_nxt = S_STAT;
        end else begin
          prod_nxt  = PROD_W'(num[NUM_W-2:0]) * PROD_W'(blm_pkg::PCT_MAX);
          state_nxt = S_PCTGO;
        end
      end
      S_PCTGO: state_nxt = S_PCTW;
      S_PCTW: begin
        if (div_done) begin
          pct_nxt   = (div_quo > DIV_W'(blm_pkg::PCT_MAX)) ? blm_pkg::PCT_MAX
                                                           : div_quo[6:0];
          state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (step != status_r) begin
          if (hold_r >= cfg.hold_count) begin
            status_nxt = step;
            hold_nxt   = 3'd0;
          end else begin
            hold_nxt = hold_r + 3'd1;
          end
        end else begin
          hold_nxt = 3'd0;
        end
        out_valid_nxt = 1'b1;
        out_nxt       = '{percent: pct_r, level_status: status_nxt, sampled: 1'b1};
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      wi_r        <= '0;
      tick_r      <= 8'd0;
      full_r      <= blm_pkg::FULL_LEVEL_RST;
      pct_r       <= blm_pkg::PCT_MAX;
      status_r    <= blm_pkg::STATUS_RST;
      hold_r      <= blm_pkg::HOLD_CNT_RST;
      rd_idx_r    <= '0;
      acc_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      wi_r        <= wi_nxt;
      tick_r      <= tick_nxt;
      full_r      <= full_nxt;
      pct_r       <= pct_nxt;
      status_r    <= status_nxt;
      hold_r      <= hold_nxt;
      rd_idx_r    <= rd_idx_nxt;
      acc_vld_r   <= acc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    avg_r  <= avg_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_AVGW || state_r == S_PCTW))
    else $error("divider result outside a wait state");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.percent <= blm_pkg::PCT_MAX))
    else $error("percentage above 100");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CNT_W'(SAMPLES)) && (32'(wi_r) < SAMPLES))
    else $error("window bookkeeping out of range");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.cmd == blm_pkg::CMD_TICK && tick_r != 8'd0)
      |=> (tick_r == $past(tick_r) - 8'd1))
    else $error("tick counter did not count down");

  a_sum_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AVGGO) |-> (rd_idx_r == fill_r && fill_r != '0))
    else $error("sum walk ended before all filled entries");

endmodule
